// ===== rtl/cil_pkg.sv =====
`default_nettype none

package cil_pkg;

  // Fixed field widths of one request and one result
  localparam int IDX_W  = 16;
  localparam int VAL_W  = 32;
  localparam int IN_W   = 48;  // index and value, a whole number of bytes
  localparam int STEP_W = 5;   // counts the index bits through the divider

  // Request kinds
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_READ   = 2'd1,
    OP_WRITE  = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_ACCESS,
    S_SHIFT,
    S_RESULT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_in;
    logic div_step;
    logic access;
    logic shift;
    logic dec_count;
    logic load_out;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    op_t  op;
    logic empty;
    logic div_done;
    logic more_acc;
    logic more_shift;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/cil_ctrl.sv =====
`default_nettype none

module cil_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  input  wire cil_pkg::dp_stat_t st,
  output cil_pkg::cmd_t          cmd,
  output logic                   in_tready
);

  cil_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cil_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cil_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = cil_pkg::S_DIV;
      end
      cil_pkg::S_DIV: begin
        if (st.empty) begin
          state_nxt = cil_pkg::S_RESULT;
        end else if (st.op == cil_pkg::OP_APPEND || st.div_done) begin
          state_nxt = cil_pkg::S_ACCESS;
        end
      end
      cil_pkg::S_ACCESS: begin
        if (st.op == cil_pkg::OP_REMOVE && st.more_acc) begin
          state_nxt = cil_pkg::S_SHIFT;
        end else begin
          state_nxt = cil_pkg::S_RESULT;
        end
      end
      cil_pkg::S_SHIFT: begin
        if (!st.more_shift) state_nxt = cil_pkg::S_RESULT;
      end
      cil_pkg::S_RESULT: begin
        if (st.out_free) state_nxt = cil_pkg::S_IDLE;
      end
      default: state_nxt = cil_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      cil_pkg::S_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
      end
      cil_pkg::S_DIV: begin
        cmd.div_step = !st.empty && st.op != cil_pkg::OP_APPEND && !st.div_done;
      end
      cil_pkg::S_ACCESS: begin
        cmd.access    = 1'b1;
        cmd.dec_count = st.op == cil_pkg::OP_REMOVE && !st.more_acc;
      end
      cil_pkg::S_SHIFT: begin
        cmd.shift     = 1'b1;
        cmd.dec_count = !st.more_shift;
      end
      cil_pkg::S_RESULT: begin
        cmd.load_out = st.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/cil_dp.sv =====
`default_nettype none

module cil_dp #(
  parameter  int LIST_DEPTH = 64,
  localparam int CW         = $clog2(LIST_DEPTH + 1),
  localparam int OUT_W      = ((cil_pkg::VAL_W + CW + 7) / 8) * 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire cil_pkg::cmd_t             cmd,
  output cil_pkg::dp_stat_t              st,
  input  wire logic [cil_pkg::IN_W-1:0]  in_tdata,
  input  wire logic [1:0]                in_tuser,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [OUT_W-1:0]               out_tdata,
  output logic [1:0]                     out_tuser
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int RW = CW + 1;
  localparam int VW = cil_pkg::VAL_W;
  localparam int XW = cil_pkg::IDX_W;

  // Request registers
  cil_pkg::op_t     op_r;
  cil_pkg::status_t status_r;
  logic [VW-1:0]    val_r;

  // Divider: remainder of index by count, one bit per cycle
  logic [XW-1:0]               dvd_r;
  logic [RW-1:0]               rem_r;
  logic [cil_pkg::STEP_W-1:0]  step_r;
  logic [RW-1:0]               rem_try;
  logic [RW-1:0]               rem_nxt;

  // List state
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [AW-1:0]  sp_r, sp_nxt;
  logic [VW-1:0]  mem [LIST_DEPTH];
  logic [VW-1:0]  rdata_r;

  // Memory port controls
  logic           we, re;
  logic [AW-1:0]  waddr, raddr;
  logic [VW-1:0]  wdata;

  logic [AW-1:0]  pos;
  logic [RW-1:0]  pos_p1, sp_p2;
  logic           more_acc, more_shift;

  // Output register
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;
  logic [1:0]       out_user_r;
  logic             out_free;

  cil_pkg::op_t     op_in;
  cil_pkg::status_t status_in;

  assign op_in = cil_pkg::op_t'(in_tuser);

  // Status of a new request, known at acceptance
  always_comb begin
    status_in = cil_pkg::ST_DONE;
    if (op_in == cil_pkg::OP_APPEND) begin
      if (cnt_r >= CW'(LIST_DEPTH)) status_in = cil_pkg::ST_FULL;
    end else if (cnt_r == '0) begin
      status_in = cil_pkg::ST_EMPTY;
    end
  end

  // Restoring step: shift in next index bit, subtract count if it fits
  assign rem_try = {rem_r[RW-2:0], dvd_r[XW-1]};
  assign rem_nxt = (rem_try >= {1'b0, cnt_r}) ? rem_try - {1'b0, cnt_r} : rem_try;

  assign pos        = rem_r[AW-1:0];
  assign pos_p1     = RW'(pos) + RW'(1);
  assign sp_p2      = RW'(sp_r) + RW'(2);
  assign more_acc   = pos_p1 < {1'b0, cnt_r};
  assign more_shift = sp_p2 < {1'b0, cnt_r};

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r     <= op_in;
      status_r <= status_in;
      val_r    <= in_tdata[XW +: VW];
      dvd_r    <= in_tdata[XW-1:0];
      rem_r    <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[XW-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (cmd.load_in) begin
      step_r <= '0;
    end else if (cmd.div_step) begin
      step_r <= step_r + cil_pkg::STEP_W'(1);
    end
  end

  // Memory port selection per command
  always_comb begin
    we      = 1'b0;
    re      = 1'b0;
    waddr   = pos;
    raddr   = pos;
    wdata   = val_r;
    sp_nxt  = sp_r;
    cnt_nxt = cnt_r;
    if (cmd.access) begin
      case (op_r)
        cil_pkg::OP_APPEND: begin
          if (status_r == cil_pkg::ST_DONE) begin
            we      = 1'b1;
            waddr   = cnt_r[AW-1:0];
            cnt_nxt = cnt_r + CW'(1);
          end
        end
        cil_pkg::OP_READ: re = 1'b1;
        cil_pkg::OP_WRITE: we = 1'b1;
        cil_pkg::OP_REMOVE: begin
          if (more_acc) begin
            re     = 1'b1;
            raddr  = pos_p1[AW-1:0];
            sp_nxt = pos;
          end
        end
        default: we = 1'b0;
      endcase
    end
    // Close the gap: move entry sp+1 down to sp, prefetch sp+2
    if (cmd.shift) begin
      we    = 1'b1;
      waddr = sp_r;
      wdata = rdata_r;
      if (more_shift) begin
        re     = 1'b1;
        raddr  = sp_p2[AW-1:0];
        sp_nxt = sp_r + AW'(1);
      end
    end
    if (cmd.dec_count) cnt_nxt = cnt_r - CW'(1);
  end

  // Value store
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    sp_r <= sp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Result beat
  always_comb begin
    out_data_nxt = '0;
    if (op_r == cil_pkg::OP_READ && status_r == cil_pkg::ST_DONE) begin
      out_data_nxt[VW-1:0] = rdata_r;
    end
    out_data_nxt[VW +: CW] = cnt_r;
  end

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= out_data_nxt;
      out_user_r <= status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Status to controller
  always_comb begin
    st.op         = op_r;
    st.empty      = status_r == cil_pkg::ST_EMPTY;
    st.div_done   = step_r == cil_pkg::STEP_W'(XW);
    st.more_acc   = more_acc;
    st.more_shift = more_shift;
    st.out_free   = out_free;
  end

endmodule

`default_nettype wire

// ===== rtl/circular_indexed_list.sv =====
// Input beat to result beat: append passes DIV, ACCESS and RESULT; a request on an empty list
// goes from DIV to RESULT; read and overwrite form the bit-serial index remainder in DIV, then
// ACCESS and RESULT; remove adds SHIFT, moving one entry per cycle through the store,
// (count - 1 - slot) entries in all. RESULT waits while an earlier result holds the output
// register. One request at a time: the next beat is taken the cycle after the result is queued.
// Reset (rst_n, synchronous, active low) empties the list; store contents are not cleared.
`default_nettype none

module circular_indexed_list #(
  parameter int LIST_DEPTH = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  // [15:0] index, [47:16] value
  input  wire logic [cil_pkg::IN_W-1:0]  in_tdata,
  // [1:0] operation
  input  wire logic [1:0]                in_tuser,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  // [31:0] read_value, then element_count, zero padded to whole bytes
  output logic [((cil_pkg::VAL_W + $clog2(LIST_DEPTH + 1) + 7) / 8) * 8 - 1:0] out_tdata,
  // [1:0] status
  output logic [1:0]                     out_tuser
);

  cil_pkg::cmd_t     cmd;
  cil_pkg::dp_stat_t st;

  cil_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .st        (st),
    .cmd       (cmd),
    .in_tready (in_tready)
  );

  cil_dp #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire
